/* rtl/tpt_pkg.sv */
// Package with the payload types, widths and constants of the thermopile pixel temperature block.
package tpt_pkg;

  localparam int PIXEL_COUNT   = 64;
  localparam int IDX_W         = 6;
  localparam int IDX_MOD_STEPS = (1 << IDX_W) / PIXEL_COUNT;

  localparam int EMIS_W     = 16;
  localparam int KS4_W      = 32;
  localparam int AMB_W      = 37;
  localparam int CFG_DATA_W = 37;
  localparam int CFG_IDX_W  = 2;

  localparam int MAG_W     = 25;
  localparam int EA_W      = 48;
  localparam int Q1_SHIFT  = 83;
  localparam int Q1_W      = MAG_W + Q1_SHIFT;
  localparam int X1_W      = Q1_W + 1;
  localparam int R1_IW     = X1_W + 1;
  localparam int R1_RW     = R1_IW / 2;
  localparam int S_IW      = R1_RW + 1;
  localparam int S_W       = S_IW / 2;
  localparam int SDIFF_W   = S_W + 1;
  localparam int P_W       = KS4_W + SDIFF_W;
  localparam int G_W       = P_W + 1;
  localparam int HALF_W    = G_W / 2;
  localparam int PP_W      = EA_W + HALF_W;
  localparam int D2_W      = EA_W + G_W;
  localparam int CAP_SHIFT = 52;
  localparam int Q2_W      = 71;
  localparam int X2_W      = Q2_W + 1;
  localparam int TQ_SHIFT  = 32;
  localparam int R2_IW     = X2_W + 32;
  localparam int R2_RW     = R2_IW / 2;
  localparam int R_W       = R2_RW / 2;

  localparam logic [EMIS_W-1:0] EMIS_RESET = 16'd32768;
  localparam logic [KS4_W-1:0]  KS4_RESET  = 32'd0;
  localparam logic [AMB_W-1:0]  AMB_RESET  = 37'd8904000000;

  localparam logic signed [SDIFF_W-1:0] ZERO_C_Q8    = 29'sd69926;
  localparam logic signed [G_W-1:0]     G_ONE        = 62'sh100_0000_0000;
  localparam logic [32:0]               CENTI_SCALE  = 33'd100;
  localparam logic [32:0]               ROUND_HALF   = 33'd32768;
  localparam logic signed [17:0]        ZERO_C_CENTI = 18'sd27315;
  localparam logic signed [17:0]        TEMP_MAX     = 18'sd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMISSIVITY = 2'd0,
    REG_KS4        = 2'd1,
    REG_AMBIENT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] pixel_raw;
    logic signed [23:0] pixel_offset;
    logic [31:0]        pixel_alpha;
    logic [5:0]         pixel_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [3:0]         column;
    logic [1:0]         row;
    logic               math_error;
  } out_item_t;

  typedef struct packed {
    logic [3:0] column;
    logic [1:0] row;
    logic       err;
  } tag_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [EA_W-1:0]  ea;
    tag_t             tag;
  } item_side_t;

  typedef struct packed {
    logic cap;
    logic neg;
    tag_t tag;
  } div2_side_t;

endpackage

/* rtl/thermopile_pixel_temperature.sv */
// Top level of the thermopile pixel temperature pipeline with configuration and output buffer.
// The block takes one pixel transaction per clock while in_stall_o is low; its object
// temperature passes one front stage, a 108-stage divider for the signal over sensitivity,
// a radicand stage, square-root pipelines of 55 and 28 stages for the first fourth root,
// six stages for the ks4 factor and the second divisor, a 71-stage divider, one sum stage,
// two square-root pipelines (52 and 26 stages) for the final fourth root and the output
// register. The whole pipeline moves together; a two-entry output buffer keeps it running
// while one finished transaction waits, and in_stall_o rises only when both entries are full.
// Configuration registers may be written only while no transaction is in flight.
module thermopile_pixel_temperature (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  tpt_pkg::in_item_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tpt_pkg::out_item_t                    out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [tpt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tpt_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  import tpt_pkg::*;

  localparam int ISW   = $bits(item_side_t);
  localparam int DSW   = $bits(div2_side_t);
  localparam int TSW   = $bits(tag_t);
  localparam int EAH_W = EA_W / 2;

  logic adv;

  logic [EMIS_W-1:0]       emis_q;
  logic signed [KS4_W-1:0] ks4_q;
  logic [AMB_W-1:0]        amb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emis_q <= EMIS_RESET;
      ks4_q  <= KS4_RESET;
      amb_q  <= AMB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EMISSIVITY: emis_q <= cfg_data_i[EMIS_W-1:0];
        REG_KS4:        ks4_q  <= cfg_data_i[KS4_W-1:0];
        REG_AMBIENT:    amb_q  <= cfg_data_i[AMB_W-1:0];
        default: ;
      endcase
    end
  end

  // Front stage.
  logic [IDX_W-1:0] idx;
  logic [MAG_W-1:0] a_diff;
  item_side_t       a_side_d, a_side_q;
  logic             a_valid_q;

  always_comb begin
    idx = in_data_i.pixel_index;
    for (int i = 0; i < IDX_MOD_STEPS; i++) begin
      if ({1'b0, idx} >= (IDX_W+1)'(PIXEL_COUNT)) begin
        idx = idx - IDX_W'(PIXEL_COUNT);
      end
    end
  end

  assign a_diff = {in_data_i.pixel_raw[15], in_data_i.pixel_raw, 8'b0}
                - {in_data_i.pixel_offset[23], in_data_i.pixel_offset};

  always_comb begin
    a_side_d.mag        = a_diff[MAG_W-1] ? (~a_diff + MAG_W'(1)) : a_diff;
    a_side_d.neg        = a_diff[MAG_W-1];
    a_side_d.ea         = {{(EA_W-EMIS_W){1'b0}}, emis_q}
                        * {{(EA_W-32){1'b0}}, in_data_i.pixel_alpha};
    a_side_d.tag.column = idx[3:0];
    a_side_d.tag.row    = idx[5:4];
    a_side_d.tag.err    = (emis_q == '0) || (in_data_i.pixel_alpha == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q <= a_side_d;
    end
  end

  // Signal over sensitivity.
  logic            d1_valid;
  logic [Q1_W-1:0] d1_quot;
  item_side_t      d1_side;

  tpt_div_pipe #(.DW(EA_W), .QW(Q1_W), .SW(ISW)) u_div1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (a_valid_q),
    .rem_i    ('0),
    .stream_i ({a_side_q.mag, {Q1_SHIFT{1'b0}}}),
    .den_i    (a_side_q.ea),
    .side_i   (a_side_q),
    .valid_o  (d1_valid),
    .quot_o   (d1_quot),
    .side_o   (d1_side)
  );

  // First radicand.
  logic [X1_W-1:0] tq1;
  logic [X1_W-1:0] q1_ext;
  logic [X1_W-1:0] b_x1_q;
  item_side_t      b_side_d, b_side_q;
  logic            b_valid_q;

  assign tq1    = {{(X1_W-AMB_W-TQ_SHIFT){1'b0}}, amb_q, {TQ_SHIFT{1'b0}}};
  assign q1_ext = {1'b0, d1_quot};

  always_comb begin
    b_side_d         = d1_side;
    b_side_d.tag.err = d1_side.tag.err || (d1_side.neg && (q1_ext > tq1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_x1_q   <= d1_side.neg ? (tq1 - q1_ext) : (tq1 + q1_ext);
      b_side_q <= b_side_d;
    end
  end

  // First fourth root as two square roots.
  logic             r1a_valid;
  logic [R1_RW-1:0] r1a_root;
  item_side_t       r1a_side;
  logic             r1b_valid;
  logic [S_W-1:0]   r1b_root;
  item_side_t       r1b_side;

  tpt_sqrt_pipe #(.IW(R1_IW), .SW(ISW)) u_sqrt1a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (b_valid_q),
    .rad_i   ({1'b0, b_x1_q}),
    .side_i  (b_side_q),
    .valid_o (r1a_valid),
    .root_o  (r1a_root),
    .side_o  (r1a_side)
  );

  tpt_sqrt_pipe #(.IW(S_IW), .SW(ISW)) u_sqrt1b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (r1a_valid),
    .rad_i   ({1'b0, r1a_root}),
    .side_i  (r1a_side),
    .valid_o (r1b_valid),
    .root_o  (r1b_root),
    .side_o  (r1b_side)
  );

  // ks4 factor and second divisor.
  logic signed [SDIFF_W-1:0] s_diff;
  logic signed [P_W-1:0]     c_p_q;
  item_side_t                c_side_q;
  logic                      c_valid_q;
  logic signed [G_W-1:0]     g_val;
  logic [G_W-1:0]            d_mg_q;
  item_side_t                d_side_d, d_side_q;
  logic                      d_valid_q;
  logic [PP_W-1:0]           e_plo_q;
  logic [G_W-HALF_W-1:0]     e_mghi_q;
  item_side_t                e_side_q;
  logic                      e_valid_q;
  logic [PP_W-1:0]           f_plo_q;
  logic [PP_W-1:0]           f_phi_q;
  item_side_t                f_side_q;
  logic                      f_valid_q;
  logic [D2_W-1:0]           h_den_q;
  item_side_t                h_side_q;
  logic                      h_valid_q;
  logic [D2_W-1:0]           i_den_q;
  div2_side_t                i_side_d, i_side_q;
  logic                      i_valid_q;
  logic [D2_W-1:0]           cap_num;
  logic [D2_W-1:0]           cap_rem_q;

  assign s_diff = $signed({1'b0, r1b_root}) - ZERO_C_Q8;
  assign g_val  = G_ONE + {c_p_q[P_W-1], c_p_q};

  always_comb begin
    d_side_d         = c_side_q;
    d_side_d.neg     = c_side_q.neg ^ g_val[G_W-1];
    d_side_d.tag.err = c_side_q.tag.err || (g_val == '0);
  end

  assign cap_num = {{(D2_W-MAG_W-CAP_SHIFT){1'b0}}, h_side_q.mag, {CAP_SHIFT{1'b0}}};

  always_comb begin
    i_side_d.cap = cap_num >= h_den_q;
    i_side_d.neg = h_side_q.neg;
    i_side_d.tag = h_side_q.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
      i_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= r1b_valid;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      h_valid_q <= f_valid_q;
      i_valid_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_p_q    <= ks4_q * s_diff;
      c_side_q <= r1b_side;
      d_mg_q   <= g_val[G_W-1] ? G_W'(-g_val) : G_W'(g_val);
      d_side_q <= d_side_d;
      e_plo_q  <= (({{(PP_W-EAH_W){1'b0}}, d_side_q.ea[EA_W-1:EAH_W]}
                  * {{(PP_W-HALF_W){1'b0}}, d_mg_q[HALF_W-1:0]}) << EAH_W)
                + ({{(PP_W-EAH_W){1'b0}}, d_side_q.ea[EAH_W-1:0]}
                  * {{(PP_W-HALF_W){1'b0}}, d_mg_q[HALF_W-1:0]});
      e_mghi_q <= d_mg_q[G_W-1:HALF_W];
      e_side_q <= d_side_q;
      f_plo_q  <= e_plo_q;
      f_phi_q  <= (({{(PP_W-EAH_W){1'b0}}, e_side_q.ea[EA_W-1:EAH_W]}
                  * {{(PP_W-(G_W-HALF_W)){1'b0}}, e_mghi_q}) << EAH_W)
                + ({{(PP_W-EAH_W){1'b0}}, e_side_q.ea[EAH_W-1:0]}
                  * {{(PP_W-(G_W-HALF_W)){1'b0}}, e_mghi_q});
      f_side_q <= e_side_q;
      h_den_q  <= {{(D2_W-PP_W){1'b0}}, f_plo_q} + {f_phi_q[D2_W-HALF_W-1:0], {HALF_W{1'b0}}};
      h_side_q <= f_side_q;
      i_den_q  <= h_den_q;
      i_side_q <= i_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cap_rem_q <= cap_num;
    end
  end

  // Signal over sensitivity and ks4 factor, capped.
  logic            d2_valid;
  logic [Q2_W-1:0] d2_quot;
  div2_side_t      d2_side;

  tpt_div_pipe #(.DW(D2_W), .QW(Q2_W), .SW(DSW)) u_div2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (i_valid_q),
    .rem_i    (cap_rem_q),
    .stream_i ('0),
    .den_i    (i_den_q),
    .side_i   (i_side_q),
    .valid_o  (d2_valid),
    .quot_o   (d2_quot),
    .side_o   (d2_side)
  );

  // Second radicand.
  logic [X2_W-1:0] tq2;
  logic [X2_W-1:0] q2_ext;
  logic [X2_W-1:0] j_x2_q;
  tag_t            j_tag_q;
  logic            j_valid_q;

  assign tq2    = {{(X2_W-AMB_W-TQ_SHIFT){1'b0}}, amb_q, {TQ_SHIFT{1'b0}}};
  assign q2_ext = d2_side.cap ? {1'b1, {Q2_W{1'b0}}} : {1'b0, d2_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q <= 1'b0;
    end else if (adv) begin
      j_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j_x2_q         <= d2_side.neg ? (tq2 - q2_ext) : (tq2 + q2_ext);
      j_tag_q.column <= d2_side.tag.column;
      j_tag_q.row    <= d2_side.tag.row;
      j_tag_q.err    <= d2_side.tag.err || (d2_side.neg && (q2_ext > tq2));
    end
  end

  // Final fourth root as two square roots.
  logic             r2a_valid;
  logic [R2_RW-1:0] r2a_root;
  tag_t             r2a_tag;
  logic             r2b_valid;
  logic [R_W-1:0]   r2b_root;
  tag_t             r2b_tag;

  tpt_sqrt_pipe #(.IW(R2_IW), .SW(TSW)) u_sqrt2a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (j_valid_q),
    .rad_i   ({j_x2_q, {(R2_IW-X2_W){1'b0}}}),
    .side_i  (j_tag_q),
    .valid_o (r2a_valid),
    .root_o  (r2a_root),
    .side_o  (r2a_tag)
  );

  tpt_sqrt_pipe #(.IW(R2_RW), .SW(TSW)) u_sqrt2b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (r2a_valid),
    .rad_i   (r2a_root),
    .side_i  (r2a_tag),
    .valid_o (r2b_valid),
    .root_o  (r2b_root),
    .side_o  (r2b_tag)
  );

  // Conversion to centidegrees.
  logic [32:0]        centi_sum;
  logic signed [17:0] temp_wide;
  out_item_t          res;

  assign centi_sum = ({{(33-R_W){1'b0}}, r2b_root} * CENTI_SCALE) + ROUND_HALF;
  assign temp_wide = $signed({1'b0, centi_sum[32:16]}) - ZERO_C_CENTI;

  always_comb begin
    res.column     = r2b_tag.column;
    res.row        = r2b_tag.row;
    res.math_error = r2b_tag.err;
    if (r2b_tag.err) begin
      res.temperature = '0;
    end else if (temp_wide > TEMP_MAX) begin
      res.temperature = TEMP_MAX[15:0];
    end else begin
      res.temperature = temp_wide[15:0];
    end
  end

  // Output register with skid entry.
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, skid_data_q;
  logic      push;
  logic      pop;

  assign adv  = !skid_valid_q;
  assign push = r2b_valid && adv;
  assign pop  = out_valid_q && !out_stall_i;

  always_comb begin
    if (pop || !out_valid_q) begin
      out_valid_d  = skid_valid_q || push;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d  = 1'b1;
      skid_valid_d = skid_valid_q || push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end else if (push) begin
      skid_data_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a transaction while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i))
    else $error("skid entry filled without a stalled output");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.math_error) |-> (out_data_o.temperature == '0))
    else $error("error transaction carries a nonzero temperature");

  a_temp_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.math_error) |-> (out_data_o.temperature >= -16'sd27315))
    else $error("temperature below absolute zero");

endmodule

/* rtl/tpt_div_pipe.sv */
// Pipelined restoring divider that produces one quotient bit per register stage.
module tpt_div_pipe #(
  parameter int DW = 48,
  parameter int QW = 108,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] stream_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [QW];
  logic [DW-1:0] rem_q   [QW];
  logic [QW-1:0] str_q   [QW];
  logic [DW-1:0] den_q   [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          valid_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] str_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = rem_i;
      assign den_in   = den_i;
      assign str_in   = stream_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign str_in   = str_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign trial = {rem_in, str_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        str_q[k]  <= {str_in[QW-2:0], take};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = str_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

/* rtl/tpt_sqrt_pipe.sv */
// Pipelined digit-by-digit integer square root that resolves one root bit per register stage.
module tpt_sqrt_pipe #(
  parameter int IW = 110,
  parameter int SW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [IW-1:0]      rad_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [IW/2-1:0]    root_o,
  output logic [SW-1:0]      side_o
);

  localparam int RW = IW / 2;

  logic          valid_q [RW];
  logic [IW-1:0] rad_q   [RW];
  logic [RW-1:0] root_q  [RW];
  logic [RW+1:0] rem_q   [RW];
  logic [SW-1:0] side_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          valid_in;
    logic [IW-1:0] rad_in;
    logic [RW-1:0] root_in;
    logic [RW+1:0] rem_in;
    logic [SW-1:0] side_in;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          take;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rad_in   = rad_i;
      assign root_in  = '0;
      assign rem_in   = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rad_in   = rad_q[k-1];
      assign root_in  = root_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign cur   = {rem_in, rad_in[IW-1:IW-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rad_q[k]  <= {rad_in[IW-3:0], 2'b00};
        root_q[k] <= {root_in[RW-2:0], take};
        rem_q[k]  <= take ? diff[RW+1:0] : cur[RW+1:0];
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule
